// ----- rtl/nss_pkg.sv -----
// ----------------------------------------------------------------------------
// nss_pkg
// Types, constants and helpers shared by the Numerov stepper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nss_pkg;

    localparam int unsigned MUL_W      = 64;
    localparam int unsigned PROD_W     = 2 * MUL_W;
    localparam int unsigned OUT_IDX_W  = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [63:0] Q_ONE    = 64'h0000_0100_0000_0000;
    localparam logic [63:0] PROD_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] W_CAP    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] DIV_TWELVE = 64'd12;
    localparam logic [63:0] DIV_SIX    = 64'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POTENTIAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd2;

    localparam logic [30:0] STEP_SIZE_RESET = 31'd10995116;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] first_value;
        logic [63:0] second_value;
    } t_in;

    typedef struct packed {
        logic [63:0]          sample;
        logic [OUT_IDX_W-1:0] sample_index;
        logic                 saturated;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HH,
        ST_POS,
        ST_X,
        ST_U,
        ST_P2,
        ST_V,
        ST_P4,
        ST_WFIN,
        ST_CDIV,
        ST_MA,
        ST_MB,
        ST_DIV,
        ST_OUT
    } t_state;

    // unsigned Q.40 product: drop 40 fraction bits, clamp to PROD_CAP
    function automatic logic [63:0] mulq_fix(input logic [PROD_W-1:0] p);
        logic [23:0] hi;
        logic [63:0] lo;
        hi = p[127:104];
        lo = p[103:40];
        if (hi != 24'd0 || lo > PROD_CAP) begin
            return PROD_CAP;
        end
        return lo;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nss_mul.sv -----
// ----------------------------------------------------------------------------
// nss_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nss_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [nss_pkg::MUL_W-1:0]  i_a,
    input  wire logic [nss_pkg::MUL_W-1:0]  i_b,
    output logic                            o_done,
    output logic [nss_pkg::PROD_W-1:0]      o_product
);

    logic [nss_pkg::MUL_W-1:0] r_a;
    logic [nss_pkg::MUL_W-1:0] r_hi;
    logic [nss_pkg::MUL_W-1:0] r_lo;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [nss_pkg::MUL_W:0]   sum;

    assign sum = {1'b0, r_hi} + {1'b0, (r_lo[0] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // add and shift right one bit
                r_hi  <= sum[nss_pkg::MUL_W:1];
                r_lo  <= {sum[0], r_lo[nss_pkg::MUL_W-1:1]};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

// ----- rtl/nss_div.sv -----
// ----------------------------------------------------------------------------
// nss_div
// Restoring radix-2 divider, 128-bit dividend by 64-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module nss_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [nss_pkg::PROD_W-1:0] i_num,
    input  wire logic [nss_pkg::MUL_W-1:0]  i_den,
    output logic                            o_done,
    output logic [nss_pkg::PROD_W-1:0]      o_quot
);

    logic [nss_pkg::PROD_W-1:0] r_q;
    logic [nss_pkg::MUL_W-1:0]  r_rem;
    logic [nss_pkg::MUL_W-1:0]  r_den;
    logic [6:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [nss_pkg::MUL_W:0]    trial;
    logic                       fits;

    assign trial = {r_rem, r_q[nss_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // shift in one dividend bit, shift out one quotient bit
                if (fits) begin
                    r_rem <= trial[nss_pkg::MUL_W-1:0] - r_den;
                end else begin
                    r_rem <= trial[nss_pkg::MUL_W-1:0];
                end
                r_q   <= {r_q[nss_pkg::PROD_W-2:0], fits};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- rtl/numerov_schroedinger_stepper_unit.sv -----
// ----------------------------------------------------------------------------
// numerov_schroedinger_stepper_unit
// Numerov integrator for y'' = -(2E - 2V(x)) y in fixed point.
// ----------------------------------------------------------------------------
// Usage: write energy, potential mode and step size on the configuration
// channel while idle (ready is always high). Send a start request (op 0)
// with y(0) and y(h), then one advance request (op 1) per new sample.
// Each request returns exactly one result: sample, grid index, saturation.
// A start request goes through the output state to the output register. An
// advance request makes thirteen (harmonic) or nineteen (anharmonic) passes
// through the serial multiplier and four through the serial divider (three
// for a zero divisor), all in sequence. One request is in work at a time;
// the input stalls until its result sits in the output register, so the
// output register may still hold an older result while the next request is
// accepted. Reset clears the samples, the index, energy, mode and control
// state (step size returns to about 1e-5), not the working or output data
// registers. A stalled receiver holds the result; the block waits in its
// final step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module numerov_schroedinger_stepper_unit #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned INDEX_BITS = 20
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire nss_pkg::t_in                     i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output nss_pkg::t_out                         o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [nss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [64:0] LIM_WIDE = (65'd1 << (VALUE_BITS - 1)) - 65'd1;
    localparam logic [63:0] LIM_POS  = LIM_WIDE[63:0];
    localparam logic [63:0] LIM_NEG  = ~LIM_POS;
    localparam logic [63:0] LIM_MAG  = LIM_POS + 64'd1;

    nss_pkg::t_state r_state, n_state;
    logic            r_wait, n_wait;
    logic [1:0]      r_k, n_k;
    logic [INDEX_BITS-1:0] r_i, n_i, r_index, n_index;
    logic [63:0]     r_latest, n_latest, r_earlier, n_earlier;
    logic            r_sat, n_sat;
    logic [29:0]     r_energy, n_energy;
    logic            r_mode, n_mode;
    logic [30:0]     r_h, n_h;
    logic [63:0]     r_hh, n_hh, r_pos, n_pos, r_x, n_x, r_u, n_u, r_v, n_v;
    logic [63:0]     r_neg, n_neg;
    logic [63:0]     r_wi, n_wi, r_w1, n_w1, r_w2, n_w2;
    logic [63:0]     r_cc, n_cc, r_ca, n_ca, r_cb, n_cb;
    logic [127:0]    r_num, n_num;
    nss_pkg::t_out   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            mul_start, mul_done;
    logic [63:0]     mul_a, mul_b;
    logic [127:0]    mul_p;
    logic            div_start, div_done;
    logic [127:0]    div_num, div_q;
    logic [63:0]     div_den;

    logic [INDEX_BITS-1:0] j;
    logic [63:0]     mq, mq_cap, p4_sum;
    logic [63:0]     w_sel, w_mag, cq, cq_signed;
    logic [66:0]     w_ext, five_w, five_mag;
    logic            w_neg;
    logic [63:0]     ca_mag, cb_mag, cc_mag, lat_mag, ear_mag;
    logic            sa, sb, nneg, qneg;
    logic [127:0]    num_mag;
    logic [INDEX_BITS+nss_pkg::OUT_IDX_W-1:0] idx_ext;
    logic [63:0]     y_val;
    logic            y_sat;
    logic [63:0]     in_first, in_second;
    logic            first_hi, first_lo, second_hi, second_lo;

    nss_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    nss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // datapath helpers
    assign j      = r_i - INDEX_BITS'(r_k);
    assign mq     = nss_pkg::mulq_fix(mul_p);
    assign mq_cap = (mq > nss_pkg::W_CAP) ? nss_pkg::W_CAP : mq;
    assign p4_sum = r_neg + mq_cap + mq_cap + mq_cap;

    always_comb begin
        case (r_k)
            2'd0:    w_sel = r_wi;
            2'd1:    w_sel = r_w1;
            default: w_sel = r_w2;
        endcase
    end
    assign w_neg     = w_sel[63];
    assign w_mag     = w_neg ? (64'd0 - w_sel) : w_sel;
    assign w_ext     = {{3{w_sel[63]}}, w_sel};
    assign five_w    = (w_ext << 2) + w_ext;
    assign five_mag  = w_neg ? (67'd0 - five_w) : five_w;
    assign cq        = div_q[63:0];
    assign cq_signed = w_neg ? (64'd0 - cq) : cq;

    assign ca_mag  = r_ca[63] ? (64'd0 - r_ca) : r_ca;
    assign cb_mag  = r_cb[63] ? (64'd0 - r_cb) : r_cb;
    assign cc_mag  = r_cc[63] ? (64'd0 - r_cc) : r_cc;
    assign lat_mag = r_latest[63] ? (64'd0 - r_latest) : r_latest;
    assign ear_mag = r_earlier[63] ? (64'd0 - r_earlier) : r_earlier;
    assign sa      = r_ca[63] ^ r_latest[63];
    assign sb      = r_cb[63] ^ r_earlier[63];
    assign nneg    = r_num[127];
    assign num_mag = nneg ? (128'd0 - r_num) : r_num;
    assign qneg    = nneg ^ r_cc[63];

    // clamp the quotient to the sample range
    always_comb begin
        y_sat = 1'b0;
        if (qneg) begin
            if (div_q[127:64] != 64'd0 || div_q[63:0] > LIM_MAG) begin
                y_sat = 1'b1;
                y_val = 64'd0 - LIM_MAG;
            end else begin
                y_val = 64'd0 - div_q[63:0];
            end
        end else begin
            if (div_q[127:64] != 64'd0 || div_q[63:0] > LIM_POS) begin
                y_sat = 1'b1;
                y_val = LIM_POS;
            end else begin
                y_val = div_q[63:0];
            end
        end
    end

    assign first_hi  = $signed(i_in_data.first_value) > $signed(LIM_POS);
    assign first_lo  = $signed(i_in_data.first_value) < $signed(LIM_NEG);
    assign second_hi = $signed(i_in_data.second_value) > $signed(LIM_POS);
    assign second_lo = $signed(i_in_data.second_value) < $signed(LIM_NEG);
    assign in_first  = first_hi ? LIM_POS : (first_lo ? LIM_NEG : i_in_data.first_value);
    assign in_second = second_hi ? LIM_POS :
                       (second_lo ? LIM_NEG : i_in_data.second_value);

    assign idx_ext = {{nss_pkg::OUT_IDX_W{1'b0}}, r_index};

    // operand selection for the shared units
    always_comb begin
        mul_a = r_u;
        mul_b = r_u;
        unique case (r_state)
            nss_pkg::ST_HH: begin
                mul_a = 64'(r_h);
                mul_b = 64'(r_h);
            end
            nss_pkg::ST_POS: begin
                mul_a = 64'({r_energy, 17'd0});
                mul_b = r_hh;
            end
            nss_pkg::ST_X: begin
                mul_a = 64'(j);
                mul_b = 64'(r_h);
            end
            nss_pkg::ST_U: begin
                mul_a = 64'(r_h);
                mul_b = r_x;
            end
            nss_pkg::ST_V: begin
                mul_a = r_u;
                mul_b = r_x;
            end
            nss_pkg::ST_P4: begin
                mul_a = r_v;
                mul_b = r_v;
            end
            nss_pkg::ST_MA: begin
                mul_a = ca_mag;
                mul_b = lat_mag;
            end
            nss_pkg::ST_MB: begin
                mul_a = cb_mag;
                mul_b = ear_mag;
            end
            default: begin
                mul_a = r_u;
                mul_b = r_u;
            end
        endcase
    end

    always_comb begin
        if (r_state == nss_pkg::ST_CDIV) begin
            div_num = (r_k == 2'd1) ? 128'(five_mag) : 128'(w_mag);
            div_den = (r_k == 2'd1) ? nss_pkg::DIV_SIX : nss_pkg::DIV_TWELVE;
        end else begin
            div_num = num_mag;
            div_den = cc_mag;
        end
    end

    assign mul_start = !r_wait && (r_state == nss_pkg::ST_HH || r_state == nss_pkg::ST_POS ||
                       r_state == nss_pkg::ST_X || r_state == nss_pkg::ST_U ||
                       r_state == nss_pkg::ST_P2 || r_state == nss_pkg::ST_V ||
                       r_state == nss_pkg::ST_P4 || r_state == nss_pkg::ST_MA ||
                       r_state == nss_pkg::ST_MB);
    assign div_start = !r_wait && (r_state == nss_pkg::ST_CDIV ||
                       (r_state == nss_pkg::ST_DIV && cc_mag != 64'd0));

    // next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_k         = r_k;
        n_i         = r_i;
        n_index     = r_index;
        n_latest    = r_latest;
        n_earlier   = r_earlier;
        n_sat       = r_sat;
        n_energy    = r_energy;
        n_mode      = r_mode;
        n_h         = r_h;
        n_hh        = r_hh;
        n_pos       = r_pos;
        n_x         = r_x;
        n_u         = r_u;
        n_v         = r_v;
        n_neg       = r_neg;
        n_wi        = r_wi;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_cc        = r_cc;
        n_ca        = r_ca;
        n_cb        = r_cb;
        n_num       = r_num;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nss_pkg::CFG_ENERGY:    n_energy = i_cfg_data[29:0];
                nss_pkg::CFG_POTENTIAL: n_mode   = i_cfg_data[0];
                nss_pkg::CFG_STEP_SIZE: n_h      = i_cfg_data;
                default: ;
            endcase
        end

        if (mul_start || div_start) begin
            n_wait = 1'b1;
        end
        if (mul_done || div_done) begin
            n_wait = 1'b0;
        end

        unique case (r_state)
            nss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.op == nss_pkg::OP_START) begin
                        n_earlier = in_first;
                        n_latest  = in_second;
                        n_sat     = second_hi || second_lo;
                        n_index   = INDEX_BITS'(1);
                        n_state   = nss_pkg::ST_OUT;
                    end else begin
                        n_i     = r_index + INDEX_BITS'(1);
                        n_k     = 2'd0;
                        n_state = nss_pkg::ST_HH;
                    end
                end
            end
            nss_pkg::ST_HH: begin
                if (mul_done) begin
                    n_hh    = mq;
                    n_state = nss_pkg::ST_POS;
                end
            end
            nss_pkg::ST_POS: begin
                if (mul_done) begin
                    n_pos   = mq;
                    n_state = nss_pkg::ST_X;
                end
            end
            nss_pkg::ST_X: begin
                if (mul_done) begin
                    n_x     = mul_p[63:0];
                    n_state = nss_pkg::ST_U;
                end
            end
            nss_pkg::ST_U: begin
                if (mul_done) begin
                    n_u     = mq;
                    n_state = nss_pkg::ST_P2;
                end
            end
            nss_pkg::ST_P2: begin
                if (mul_done) begin
                    n_neg   = mq_cap;
                    n_state = r_mode ? nss_pkg::ST_V : nss_pkg::ST_WFIN;
                end
            end
            nss_pkg::ST_V: begin
                if (mul_done) begin
                    n_v     = mq;
                    n_state = nss_pkg::ST_P4;
                end
            end
            nss_pkg::ST_P4: begin
                if (mul_done) begin
                    n_neg   = (p4_sum > nss_pkg::W_CAP) ? nss_pkg::W_CAP : p4_sum;
                    n_state = nss_pkg::ST_WFIN;
                end
            end
            nss_pkg::ST_WFIN: begin
                case (r_k)
                    2'd0:    n_wi = r_pos - r_neg;
                    2'd1:    n_w1 = r_pos - r_neg;
                    default: n_w2 = r_pos - r_neg;
                endcase
                if (r_k == 2'd2) begin
                    n_k     = 2'd0;
                    n_state = nss_pkg::ST_CDIV;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = nss_pkg::ST_X;
                end
            end
            nss_pkg::ST_CDIV: begin
                if (div_done) begin
                    case (r_k)
                        2'd0:    n_cc = nss_pkg::Q_ONE + cq_signed;
                        2'd1:    n_ca = (nss_pkg::Q_ONE << 1) - cq_signed;
                        default: n_cb = nss_pkg::Q_ONE + cq_signed;
                    endcase
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = nss_pkg::ST_MA;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            nss_pkg::ST_MA: begin
                if (mul_done) begin
                    n_num   = sa ? (128'd0 - mul_p) : mul_p;
                    n_state = nss_pkg::ST_MB;
                end
            end
            nss_pkg::ST_MB: begin
                if (mul_done) begin
                    n_num   = sb ? (r_num + mul_p) : (r_num - mul_p);
                    n_state = nss_pkg::ST_DIV;
                end
            end
            nss_pkg::ST_DIV: begin
                if (!r_wait && cc_mag == 64'd0) begin
                    // zero divisor: zero stays zero, else clamp by sign
                    n_earlier = r_latest;
                    n_index   = r_i;
                    n_sat     = (r_num != 128'd0);
                    if (r_num == 128'd0) begin
                        n_latest = 64'd0;
                    end else begin
                        n_latest = nneg ? LIM_NEG : LIM_POS;
                    end
                    n_state = nss_pkg::ST_OUT;
                end else if (div_done) begin
                    n_earlier = r_latest;
                    n_latest  = y_val;
                    n_sat     = y_sat;
                    n_index   = r_i;
                    n_state   = nss_pkg::ST_OUT;
                end
            end
            nss_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sample       = r_latest;
                    n_out.sample_index = idx_ext[nss_pkg::OUT_IDX_W-1:0];
                    n_out.saturated    = r_sat;
                    n_out_valid        = 1'b1;
                    n_state            = nss_pkg::ST_IDLE;
                end
            end
            default: n_state = nss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nss_pkg::ST_IDLE;
            r_wait      <= 1'b0;
            r_k         <= '0;
            r_index     <= '0;
            r_latest    <= '0;
            r_earlier   <= '0;
            r_sat       <= 1'b0;
            r_energy    <= '0;
            r_mode      <= 1'b0;
            r_h         <= nss_pkg::STEP_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_k         <= n_k;
            r_index     <= n_index;
            r_latest    <= n_latest;
            r_earlier   <= n_earlier;
            r_sat       <= n_sat;
            r_energy    <= n_energy;
            r_mode      <= n_mode;
            r_h         <= n_h;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_hh  <= n_hh;
        r_pos <= n_pos;
        r_x   <= n_x;
        r_u   <= n_u;
        r_v   <= n_v;
        r_neg <= n_neg;
        r_wi  <= n_wi;
        r_w1  <= n_w1;
        r_w2  <= n_w2;
        r_cc  <= n_cc;
        r_ca  <= n_ca;
        r_cb  <= n_cb;
        r_num <= n_num;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != nss_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
